// ===== src/usbreq_pkg.sv =====
// ----------------------------------------------------------------------------
// usbreq_pkg
// Shared types and codes for the USB standard request responder.
// ----------------------------------------------------------------------------
package usbreq_pkg;

   localparam int MAX_INTERFACES_DEFAULT = 8;
   localparam int MAX_STRINGS            = 8;
   localparam int CSR_INDEX_W            = 8;
   localparam int CSR_DATA_W             = 64;

   // result codes
   localparam logic [2:0] RC_DATA       = 3'd0;
   localparam logic [2:0] RC_NODATA     = 3'd1;
   localparam logic [2:0] RC_STALL      = 3'd2;
   localparam logic [2:0] RC_CLASS      = 3'd3;
   localparam logic [2:0] RC_VENDOR     = 3'd4;
   localparam logic [2:0] RC_DESC_FWD   = 3'd5;
   localparam logic [2:0] RC_STRING_FWD = 3'd6;

   // data sources
   localparam logic [3:0] SRC_NONE         = 4'd0;
   localparam logic [3:0] SRC_INLINE       = 4'd1;
   localparam logic [3:0] SRC_DEVICE       = 4'd2;
   localparam logic [3:0] SRC_CONFIG       = 4'd3;
   localparam logic [3:0] SRC_STRING       = 4'd4;
   localparam logic [3:0] SRC_LANGUAGE     = 4'd5;
   localparam logic [3:0] SRC_DEFAULT_LANG = 4'd6;
   localparam logic [3:0] SRC_HID          = 4'd7;
   localparam logic [3:0] SRC_REPORT       = 4'd8;
   localparam logic [3:0] SRC_BOS          = 4'd9;

   // request types
   localparam logic [1:0] TYPE_STANDARD = 2'd0;
   localparam logic [1:0] TYPE_CLASS    = 2'd1;
   localparam logic [1:0] TYPE_VENDOR   = 2'd2;

   // standard request codes
   localparam logic [7:0] REQ_GET_STATUS        = 8'h00;
   localparam logic [7:0] REQ_CLEAR_FEATURE     = 8'h01;
   localparam logic [7:0] REQ_SET_FEATURE       = 8'h03;
   localparam logic [7:0] REQ_SET_ADDRESS       = 8'h05;
   localparam logic [7:0] REQ_GET_DESCRIPTOR    = 8'h06;
   localparam logic [7:0] REQ_GET_CONFIGURATION = 8'h08;
   localparam logic [7:0] REQ_SET_CONFIGURATION = 8'h09;
   localparam logic [7:0] REQ_GET_INTERFACE     = 8'h0A;
   localparam logic [7:0] REQ_SET_INTERFACE     = 8'h0B;

   // descriptor types
   localparam logic [7:0] DT_DEVICE      = 8'h01;
   localparam logic [7:0] DT_CONFIG      = 8'h02;
   localparam logic [7:0] DT_STRING      = 8'h03;
   localparam logic [7:0] DT_QUALIFIER   = 8'h06;
   localparam logic [7:0] DT_OTHER_SPEED = 8'h07;
   localparam logic [7:0] DT_BOS         = 8'h0F;
   localparam logic [7:0] DT_HID         = 8'h21;
   localparam logic [7:0] DT_REPORT      = 8'h22;

   // presence flag bit positions
   localparam int FLAG_DEVICE      = 0;
   localparam int FLAG_HID         = 1;
   localparam int FLAG_VENDOR      = 2;
   localparam int FLAG_CLASS       = 3;
   localparam int FLAG_DESC_FWD    = 4;
   localparam int FLAG_STRING_FWD  = 5;
   localparam int FLAG_NOTIFY      = 6;
   localparam int FLAG_LANGUAGE    = 7;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_CONFIG_COUNT    = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_STRING_COUNT    = 8'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_STRING_LENGTHS  = 8'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_CONFIG_DESC_LEN = 8'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_REPORT_DESC_LEN = 8'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_BOS_DESC_LEN    = 8'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_LANGUAGE_LEN    = 8'd6;
   localparam logic [CSR_INDEX_W-1:0] CSR_PRESENCE_FLAGS  = 8'd7;

   // fixed reply lengths
   localparam logic [15:0] LEN_DEVICE       = 16'd18;
   localparam logic [15:0] LEN_HID          = 16'd9;
   localparam logic [15:0] LEN_DEFAULT_LANG = 16'd4;
   localparam logic [15:0] LEN_STATUS       = 16'd2;
   localparam logic [15:0] LEN_BYTE         = 16'd1;

   localparam logic [4:0] RECIP_MAX = 5'd2;

   typedef struct packed {
      logic [7:0]  config_count;
      logic [3:0]  string_count;
      logic [63:0] string_lengths;
      logic [15:0] config_desc_length;
      logic [15:0] report_desc_length;
      logic [15:0] bos_desc_length;
      logic [7:0]  language_desc_length;
      logic [7:0]  presence_flags;
   } csr_type;

   typedef struct packed {
      logic [7:0]  request_type;
      logic [7:0]  request_code;
      logic [15:0] value_word;
      logic [15:0] index_word;
      logic [15:0] length_word;
   } packet_type;

   typedef struct packed {
      logic [2:0]  result_code;
      logic [3:0]  data_source;
      logic [7:0]  source_index;
      logic [15:0] inline_data;
      logic [15:0] data_length;
      logic        config_notify;
      logic [7:0]  current_config;
      logic [7:0]  current_address;
   } reply_type;

   typedef struct packed {
      logic       set_address;
      logic [7:0] address;
      logic       set_config;
      logic [7:0] cfg_value;
      logic       set_alt;
      logic [7:0] alt_index;
      logic [7:0] alt_value;
   } update_type;

endpackage

// ===== src/usbreq_csr.sv =====
// ----------------------------------------------------------------------------
// usbreq_csr
// Configuration registers written through the csr channel.
// ----------------------------------------------------------------------------
module usbreq_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_valid,
   input  logic                              csr_ready,
   input  logic [usbreq_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [usbreq_pkg::CSR_DATA_W-1:0]  csr_data,
   output usbreq_pkg::csr_type               csr_out
);

   usbreq_pkg::csr_type csr_ff;
   usbreq_pkg::csr_type csr_in;

   always_comb begin
      csr_in = csr_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            usbreq_pkg::CSR_CONFIG_COUNT:    csr_in.config_count         = csr_data[7:0];
            usbreq_pkg::CSR_STRING_COUNT:    csr_in.string_count         = csr_data[3:0];
            usbreq_pkg::CSR_STRING_LENGTHS:  csr_in.string_lengths       = csr_data;
            usbreq_pkg::CSR_CONFIG_DESC_LEN: csr_in.config_desc_length   = csr_data[15:0];
            usbreq_pkg::CSR_REPORT_DESC_LEN: csr_in.report_desc_length   = csr_data[15:0];
            usbreq_pkg::CSR_BOS_DESC_LEN:    csr_in.bos_desc_length      = csr_data[15:0];
            usbreq_pkg::CSR_LANGUAGE_LEN:    csr_in.language_desc_length = csr_data[7:0];
            usbreq_pkg::CSR_PRESENCE_FLAGS:  csr_in.presence_flags       = csr_data[7:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.config_count         <= 8'd1;
         csr_ff.string_count         <= 4'd0;
         csr_ff.string_lengths       <= 64'd0;
         csr_ff.config_desc_length   <= 16'd0;
         csr_ff.report_desc_length   <= 16'd0;
         csr_ff.bos_desc_length      <= 16'd0;
         csr_ff.language_desc_length <= 8'd4;
         csr_ff.presence_flags       <= 8'd0;
      end else begin
         csr_ff <= csr_in;
      end
   end

   assign csr_out = csr_ff;

endmodule

// ===== src/usbreq_state.sv =====
// ----------------------------------------------------------------------------
// usbreq_state
// Device address, active configuration and per-interface alternate settings.
// ----------------------------------------------------------------------------
module usbreq_state #(
   parameter int MAX_INTERFACES = usbreq_pkg::MAX_INTERFACES_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   update_en,
   input  usbreq_pkg::update_type update,
   input  logic [7:0]             alt_rd_index,
   output logic [7:0]             alt_rd_value,
   output logic [7:0]             device_address,
   output logic [7:0]             active_config
);

   localparam int IDX_W = (MAX_INTERFACES > 1) ? $clog2(MAX_INTERFACES) : 1;

   logic [7:0] address_ff;
   logic [7:0] config_ff;
   logic [7:0] alt_ff [MAX_INTERFACES];
   logic       rd_in_range;
   logic       wr_in_range;

   assign rd_in_range = {1'b0, alt_rd_index} < 9'(MAX_INTERFACES);
   assign wr_in_range = {1'b0, update.alt_index} < 9'(MAX_INTERFACES);

   always_ff @(posedge clock) begin
      if (reset) begin
         address_ff <= 8'd0;
         config_ff  <= 8'd0;
         for (int i = 0; i < MAX_INTERFACES; i++) begin
            alt_ff[i] <= 8'd0;
         end
      end else if (update_en) begin
         if (update.set_address) begin
            address_ff <= update.address;
         end
         if (update.set_config) begin
            config_ff <= update.cfg_value;
         end
         if (update.set_alt && wr_in_range) begin
            alt_ff[update.alt_index[IDX_W-1:0]] <= update.alt_value;
         end
      end
   end

   assign alt_rd_value   = rd_in_range ? alt_ff[alt_rd_index[IDX_W-1:0]] : 8'd0;
   assign device_address = address_ff;
   assign active_config  = config_ff;

endmodule

// ===== src/usbreq_decode.sv =====
// ----------------------------------------------------------------------------
// usbreq_decode
// Setup packet decode: reply fields and state updates for one transaction.
// ----------------------------------------------------------------------------
module usbreq_decode #(
   parameter int MAX_INTERFACES = usbreq_pkg::MAX_INTERFACES_DEFAULT
) (
   input  usbreq_pkg::packet_type pkt,
   input  usbreq_pkg::csr_type    csr,
   input  logic [7:0]             device_address,
   input  logic [7:0]             active_config,
   input  logic [7:0]             alt_rd_value,
   output logic [7:0]             alt_rd_index,
   output usbreq_pkg::reply_type  reply,
   output usbreq_pkg::update_type update
);

   logic [1:0]  rtype;
   logic [4:0]  recip;
   logic [7:0]  lo;
   logic [7:0]  intf;
   logic [7:0]  dtype;
   logic [7:0]  didx;
   logic        intf_ok;
   logic [3:0]  str_cnt;
   logic [2:0]  str_sel;
   logic [7:0]  str_len;
   logic [15:0] raw_len;
   logic [2:0]  code;
   logic [3:0]  src;
   logic [7:0]  idx;
   logic [15:0] inl;
   logic        notify;

   assign rtype   = pkt.request_type[6:5];
   assign recip   = pkt.request_type[4:0];
   assign lo      = pkt.value_word[7:0];
   assign dtype   = pkt.value_word[15:8];
   assign didx    = pkt.value_word[7:0];
   assign intf    = pkt.index_word[7:0];
   assign intf_ok = {1'b0, intf} < 9'(MAX_INTERFACES);
   assign str_cnt = (csr.string_count > 4'(usbreq_pkg::MAX_STRINGS)) ?
                    4'(usbreq_pkg::MAX_STRINGS) : csr.string_count;
   assign str_sel = 3'(didx - 8'd1);
   assign str_len = csr.string_lengths[{str_sel, 3'b000} +: 8];
   assign alt_rd_index = intf;

   always_comb begin
      code    = usbreq_pkg::RC_STALL;
      src     = usbreq_pkg::SRC_NONE;
      idx     = 8'd0;
      inl     = 16'd0;
      raw_len = 16'd0;
      notify  = 1'b0;
      update  = '0;
      update.address      = lo;
      update.cfg_value    = lo;
      update.alt_index    = intf;
      update.alt_value    = lo;

      unique case (rtype)
         usbreq_pkg::TYPE_STANDARD: begin
            unique case (pkt.request_code)
               usbreq_pkg::REQ_GET_DESCRIPTOR: begin
                  unique case (dtype)
                     usbreq_pkg::DT_DEVICE: begin
                        if (csr.presence_flags[usbreq_pkg::FLAG_DEVICE]) begin
                           code    = usbreq_pkg::RC_DATA;
                           src     = usbreq_pkg::SRC_DEVICE;
                           raw_len = usbreq_pkg::LEN_DEVICE;
                        end
                     end
                     usbreq_pkg::DT_CONFIG: begin
                        if (csr.config_desc_length != 16'd0 && didx < csr.config_count) begin
                           code    = usbreq_pkg::RC_DATA;
                           src     = usbreq_pkg::SRC_CONFIG;
                           idx     = didx;
                           raw_len = csr.config_desc_length;
                        end
                     end
                     usbreq_pkg::DT_STRING: begin
                        if (didx == 8'd0) begin
                           if (csr.presence_flags[usbreq_pkg::FLAG_LANGUAGE]) begin
                              if (csr.language_desc_length != 8'd0) begin
                                 code    = usbreq_pkg::RC_DATA;
                                 src     = usbreq_pkg::SRC_LANGUAGE;
                                 raw_len = {8'd0, csr.language_desc_length};
                              end
                           end else begin
                              code    = usbreq_pkg::RC_DATA;
                              src     = usbreq_pkg::SRC_DEFAULT_LANG;
                              raw_len = usbreq_pkg::LEN_DEFAULT_LANG;
                           end
                        end else if (didx <= {4'd0, str_cnt}) begin
                           if (str_len != 8'd0) begin
                              code    = usbreq_pkg::RC_DATA;
                              src     = usbreq_pkg::SRC_STRING;
                              idx     = didx;
                              raw_len = {8'd0, str_len};
                           end
                        end else if (csr.presence_flags[usbreq_pkg::FLAG_STRING_FWD]) begin
                           code = usbreq_pkg::RC_STRING_FWD;
                           idx  = didx;
                        end
                     end
                     usbreq_pkg::DT_QUALIFIER,
                     usbreq_pkg::DT_OTHER_SPEED: ;
                     usbreq_pkg::DT_HID: begin
                        if (csr.presence_flags[usbreq_pkg::FLAG_HID]) begin
                           code    = usbreq_pkg::RC_DATA;
                           src     = usbreq_pkg::SRC_HID;
                           raw_len = usbreq_pkg::LEN_HID;
                        end
                     end
                     usbreq_pkg::DT_REPORT: begin
                        if (csr.report_desc_length != 16'd0) begin
                           code    = usbreq_pkg::RC_DATA;
                           src     = usbreq_pkg::SRC_REPORT;
                           raw_len = csr.report_desc_length;
                        end
                     end
                     usbreq_pkg::DT_BOS: begin
                        if (csr.bos_desc_length != 16'd0) begin
                           code    = usbreq_pkg::RC_DATA;
                           src     = usbreq_pkg::SRC_BOS;
                           raw_len = csr.bos_desc_length;
                        end
                     end
                     default: begin
                        if (csr.presence_flags[usbreq_pkg::FLAG_DESC_FWD]) begin
                           code = usbreq_pkg::RC_DESC_FWD;
                           idx  = didx;
                        end
                     end
                  endcase
               end
               usbreq_pkg::REQ_SET_CONFIGURATION: begin
                  if (lo == 8'd0 || lo <= csr.config_count) begin
                     update.set_config = 1'b1;
                     code   = usbreq_pkg::RC_NODATA;
                     notify = csr.presence_flags[usbreq_pkg::FLAG_NOTIFY];
                  end
               end
               usbreq_pkg::REQ_GET_CONFIGURATION: begin
                  code    = usbreq_pkg::RC_DATA;
                  src     = usbreq_pkg::SRC_INLINE;
                  raw_len = usbreq_pkg::LEN_BYTE;
                  inl     = {8'd0, active_config};
               end
               usbreq_pkg::REQ_SET_ADDRESS: begin
                  update.set_address = 1'b1;
                  code = usbreq_pkg::RC_NODATA;
               end
               usbreq_pkg::REQ_GET_STATUS: begin
                  if (recip <= usbreq_pkg::RECIP_MAX) begin
                     code    = usbreq_pkg::RC_DATA;
                     src     = usbreq_pkg::SRC_INLINE;
                     raw_len = usbreq_pkg::LEN_STATUS;
                  end
               end
               usbreq_pkg::REQ_CLEAR_FEATURE,
               usbreq_pkg::REQ_SET_FEATURE: begin
                  code = usbreq_pkg::RC_NODATA;
               end
               usbreq_pkg::REQ_SET_INTERFACE: begin
                  update.set_alt = intf_ok;
                  code = usbreq_pkg::RC_NODATA;
               end
               usbreq_pkg::REQ_GET_INTERFACE: begin
                  code    = usbreq_pkg::RC_DATA;
                  src     = usbreq_pkg::SRC_INLINE;
                  raw_len = usbreq_pkg::LEN_BYTE;
                  inl     = {8'd0, alt_rd_value};
               end
               default: ;
            endcase
         end
         usbreq_pkg::TYPE_CLASS: begin
            if (csr.presence_flags[usbreq_pkg::FLAG_CLASS]) begin
               code = usbreq_pkg::RC_CLASS;
            end
         end
         usbreq_pkg::TYPE_VENDOR: begin
            if (csr.presence_flags[usbreq_pkg::FLAG_VENDOR]) begin
               code = usbreq_pkg::RC_VENDOR;
            end
         end
         default: ;
      endcase

      reply.result_code     = code;
      reply.data_source     = src;
      reply.source_index    = idx;
      reply.inline_data     = inl;
      reply.data_length     = (raw_len > pkt.length_word) ? pkt.length_word : raw_len;
      reply.config_notify   = notify;
      reply.current_config  = update.set_config ? lo : active_config;
      reply.current_address = update.set_address ? lo : device_address;
   end

endmodule

// ===== src/usb_standard_request_responder.sv =====
// ----------------------------------------------------------------------------
// usb_standard_request_responder
// Decodes USB setup packets and answers the standard requests.
//
// The req channel carries one setup packet per transaction (bmRequestType,
// bRequest, wValue, wIndex, wLength). The rsp channel returns exactly one
// reply per packet, in order: result code, data source and index, inline
// data, the byte count clamped to wLength, the notify flag and the device
// address and configuration that hold after the request.
// The csr channel writes the configuration registers and is always ready;
// the user must write it only while no transaction is in flight, as the
// block itself does not enforce this. A packet lands in an input register,
// is decoded combinationally and the reply is captured in an output
// register; one packet per cycle is sustained while rsp_ready is high.
// When rsp_ready is low the output register holds its reply, the input
// register still takes one more packet, then req_ready drops until the
// reply is taken. Reset empties both registers, clears the address,
// configuration and alternate settings and loads register defaults.
// ----------------------------------------------------------------------------
module usb_standard_request_responder #(
   parameter int MAX_INTERFACES = usbreq_pkg::MAX_INTERFACES_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,

   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [7:0]                         req_request_type,
   input  logic [7:0]                         req_request_code,
   input  logic [15:0]                        req_value_word,
   input  logic [15:0]                        req_index_word,
   input  logic [15:0]                        req_length_word,

   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [2:0]                         rsp_result_code,
   output logic [3:0]                         rsp_data_source,
   output logic [7:0]                         rsp_source_index,
   output logic [15:0]                        rsp_inline_data,
   output logic [15:0]                        rsp_data_length,
   output logic                               rsp_config_notify,
   output logic [7:0]                         rsp_current_config,
   output logic [7:0]                         rsp_current_address,

   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [usbreq_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [usbreq_pkg::CSR_DATA_W-1:0]  csr_data
);

   logic                   in_valid_ff;
   logic                   in_valid_in;
   usbreq_pkg::packet_type pkt_ff;
   logic                   out_valid_ff;
   logic                   out_valid_in;
   usbreq_pkg::reply_type  reply_ff;
   usbreq_pkg::reply_type  reply;
   usbreq_pkg::update_type update;
   usbreq_pkg::csr_type    csr;
   logic                   out_load;
   logic                   req_take;
   logic [7:0]             alt_rd_index;
   logic [7:0]             alt_rd_value;
   logic [7:0]             device_address;
   logic [7:0]             active_config;

   assign csr_ready = 1'b1;

   assign out_load  = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || out_load;
   assign req_take  = req_valid && req_ready;

   assign in_valid_in  = req_take || (in_valid_ff && !out_load);
   assign out_valid_in = out_load || (out_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         pkt_ff.request_type <= req_request_type;
         pkt_ff.request_code <= req_request_code;
         pkt_ff.value_word   <= req_value_word;
         pkt_ff.index_word   <= req_index_word;
         pkt_ff.length_word  <= req_length_word;
      end
      if (out_load) begin
         reply_ff <= reply;
      end
   end

   usbreq_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .csr_out   (csr)
   );

   usbreq_state #(
      .MAX_INTERFACES (MAX_INTERFACES)
   ) u_state (
      .clock          (clock),
      .reset          (reset),
      .update_en      (out_load),
      .update         (update),
      .alt_rd_index   (alt_rd_index),
      .alt_rd_value   (alt_rd_value),
      .device_address (device_address),
      .active_config  (active_config)
   );

   usbreq_decode #(
      .MAX_INTERFACES (MAX_INTERFACES)
   ) u_decode (
      .pkt            (pkt_ff),
      .csr            (csr),
      .device_address (device_address),
      .active_config  (active_config),
      .alt_rd_value   (alt_rd_value),
      .alt_rd_index   (alt_rd_index),
      .reply          (reply),
      .update         (update)
   );

   assign rsp_valid           = out_valid_ff;
   assign rsp_result_code     = reply_ff.result_code;
   assign rsp_data_source     = reply_ff.data_source;
   assign rsp_source_index    = reply_ff.source_index;
   assign rsp_inline_data     = reply_ff.inline_data;
   assign rsp_data_length     = reply_ff.data_length;
   assign rsp_config_notify   = reply_ff.config_notify;
   assign rsp_current_config  = reply_ff.current_config;
   assign rsp_current_address = reply_ff.current_address;

endmodule

// ===== verif/usb_standard_request_responder_test.sv =====
// ----------------------------------------------------------------------------
// usb_standard_request_responder_test
// Self-checking bench for the setup packet responder. It feeds directed and
// random setup packets through the req channel under several register
// settings, predicts every reply in step with the device state it tracks,
// and compares each rsp transaction field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module usb_standard_request_responder_test;

   localparam logic [1:0] TYPE_RESERVED      = 2'd3;
   localparam logic [7:0] REQ_SET_DESCRIPTOR = 8'h07;
   localparam int         SETUPS_PER_PHASE   = 190;
   localparam int         NO_IDLE_PHASE      = 3;
   localparam int         ALT_IDX_W          = $clog2(usbreq_pkg::MAX_INTERFACES_DEFAULT);

   localparam logic [7:0] STD_CODES [9] = '{
      usbreq_pkg::REQ_GET_STATUS, usbreq_pkg::REQ_CLEAR_FEATURE,
      usbreq_pkg::REQ_SET_FEATURE, usbreq_pkg::REQ_SET_ADDRESS,
      usbreq_pkg::REQ_GET_DESCRIPTOR, usbreq_pkg::REQ_GET_CONFIGURATION,
      usbreq_pkg::REQ_SET_CONFIGURATION, usbreq_pkg::REQ_GET_INTERFACE,
      usbreq_pkg::REQ_SET_INTERFACE};
   localparam logic [7:0] DESC_KINDS [10] = '{
      usbreq_pkg::DT_DEVICE, usbreq_pkg::DT_CONFIG, usbreq_pkg::DT_STRING,
      usbreq_pkg::DT_QUALIFIER, usbreq_pkg::DT_OTHER_SPEED, usbreq_pkg::DT_BOS,
      usbreq_pkg::DT_HID, usbreq_pkg::DT_REPORT, usbreq_pkg::DT_STRING,
      usbreq_pkg::DT_CONFIG};
   localparam int PHASE_KINDS [6] = '{0, 1, 2, 2, 2, 2};

   logic        clock = 1'b0;
   logic        reset = 1'b1;

   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_request_type = '0;
   logic [7:0]  req_request_code = '0;
   logic [15:0] req_value_word = '0;
   logic [15:0] req_index_word = '0;
   logic [15:0] req_length_word = '0;

   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [2:0]  rsp_result_code;
   logic [3:0]  rsp_data_source;
   logic [7:0]  rsp_source_index;
   logic [15:0] rsp_inline_data;
   logic [15:0] rsp_data_length;
   logic        rsp_config_notify;
   logic [7:0]  rsp_current_config;
   logic [7:0]  rsp_current_address;

   logic                               csr_valid = 1'b0;
   logic                               csr_ready;
   logic [usbreq_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [usbreq_pkg::CSR_DATA_W-1:0]  csr_data = '0;

   usbreq_pkg::csr_type regs;
   logic [7:0] device_addr = '0;
   logic [7:0] active_cfg = '0;
   logic [7:0] alt_table [usbreq_pkg::MAX_INTERFACES_DEFAULT] = '{default: '0};

   usbreq_pkg::packet_type pending_setups [$];
   usbreq_pkg::reply_type  expected_replies [$];
   usbreq_pkg::packet_type offered = '0;

   int idle_pct = 35;
   int setups_queued = 0;
   int setups_accepted = 0;
   int replies_checked = 0;
   int failures = 0;
   int settings_used = 0;
   int hold_left = 0;
   int reply_tally [8] = '{default: 0};

   usb_standard_request_responder dut (.*);

   always #5 clock = ~clock;

   function automatic usbreq_pkg::reply_type data_reply(logic [3:0] src, logic [7:0] idx,
                                                        logic [15:0] len);
      usbreq_pkg::reply_type r;
      r = '0;
      r.result_code  = usbreq_pkg::RC_DATA;
      r.data_source  = src;
      r.source_index = idx;
      r.data_length  = len;
      return r;
   endfunction

   function automatic usbreq_pkg::reply_type respond(usbreq_pkg::packet_type p);
      usbreq_pkg::reply_type r;
      logic [7:0] lo;
      logic [7:0] intf;
      logic [3:0] nstr;
      logic [7:0] slen;
      int         sidx;
      r = '0;
      r.result_code = usbreq_pkg::RC_STALL;
      lo   = p.value_word[7:0];
      intf = p.index_word[7:0];
      nstr = (regs.string_count > usbreq_pkg::MAX_STRINGS) ?
             4'(usbreq_pkg::MAX_STRINGS) : regs.string_count;
      case (p.request_type[6:5])
         usbreq_pkg::TYPE_STANDARD: begin
            case (p.request_code)
               usbreq_pkg::REQ_GET_DESCRIPTOR: begin
                  case (p.value_word[15:8])
                     usbreq_pkg::DT_DEVICE:
                        if (regs.presence_flags[usbreq_pkg::FLAG_DEVICE])
                           r = data_reply(usbreq_pkg::SRC_DEVICE, '0,
                                          usbreq_pkg::LEN_DEVICE);
                     usbreq_pkg::DT_CONFIG:
                        if (regs.config_desc_length != 0 && lo < regs.config_count)
                           r = data_reply(usbreq_pkg::SRC_CONFIG, lo,
                                          regs.config_desc_length);
                     usbreq_pkg::DT_STRING: begin
                        if (lo == 0) begin
                           if (!regs.presence_flags[usbreq_pkg::FLAG_LANGUAGE])
                              r = data_reply(usbreq_pkg::SRC_DEFAULT_LANG, '0,
                                             usbreq_pkg::LEN_DEFAULT_LANG);
                           else if (regs.language_desc_length != 0)
                              r = data_reply(usbreq_pkg::SRC_LANGUAGE, '0,
                                             {8'd0, regs.language_desc_length});
                        end else if (lo <= nstr) begin
                           sidx = lo - 1;
                           slen = regs.string_lengths[sidx*8 +: 8];
                           if (slen != 0)
                              r = data_reply(usbreq_pkg::SRC_STRING, lo, {8'd0, slen});
                        end else if (regs.presence_flags[usbreq_pkg::FLAG_STRING_FWD]) begin
                           r.result_code  = usbreq_pkg::RC_STRING_FWD;
                           r.source_index = lo;
                        end
                     end
                     usbreq_pkg::DT_QUALIFIER, usbreq_pkg::DT_OTHER_SPEED: ;
                     usbreq_pkg::DT_HID:
                        if (regs.presence_flags[usbreq_pkg::FLAG_HID])
                           r = data_reply(usbreq_pkg::SRC_HID, '0, usbreq_pkg::LEN_HID);
                     usbreq_pkg::DT_REPORT:
                        if (regs.report_desc_length != 0)
                           r = data_reply(usbreq_pkg::SRC_REPORT, '0,
                                          regs.report_desc_length);
                     usbreq_pkg::DT_BOS:
                        if (regs.bos_desc_length != 0)
                           r = data_reply(usbreq_pkg::SRC_BOS, '0, regs.bos_desc_length);
                     default:
                        if (regs.presence_flags[usbreq_pkg::FLAG_DESC_FWD]) begin
                           r.result_code  = usbreq_pkg::RC_DESC_FWD;
                           r.source_index = lo;
                        end
                  endcase
               end
               usbreq_pkg::REQ_SET_CONFIGURATION: begin
                  if (lo == 0 || lo <= regs.config_count) begin
                     active_cfg      = lo;
                     r.result_code   = usbreq_pkg::RC_NODATA;
                     r.config_notify = regs.presence_flags[usbreq_pkg::FLAG_NOTIFY];
                  end
               end
               usbreq_pkg::REQ_GET_CONFIGURATION: begin
                  r = data_reply(usbreq_pkg::SRC_INLINE, '0, usbreq_pkg::LEN_BYTE);
                  r.inline_data = {8'd0, active_cfg};
               end
               usbreq_pkg::REQ_SET_ADDRESS: begin
                  device_addr   = lo;
                  r.result_code = usbreq_pkg::RC_NODATA;
               end
               usbreq_pkg::REQ_GET_STATUS:
                  if (p.request_type[4:0] <= usbreq_pkg::RECIP_MAX)
                     r = data_reply(usbreq_pkg::SRC_INLINE, '0, usbreq_pkg::LEN_STATUS);
               usbreq_pkg::REQ_CLEAR_FEATURE, usbreq_pkg::REQ_SET_FEATURE:
                  r.result_code = usbreq_pkg::RC_NODATA;
               usbreq_pkg::REQ_SET_INTERFACE: begin
                  if (intf < usbreq_pkg::MAX_INTERFACES_DEFAULT)
                     alt_table[intf[ALT_IDX_W-1:0]] = lo;
                  r.result_code = usbreq_pkg::RC_NODATA;
               end
               usbreq_pkg::REQ_GET_INTERFACE: begin
                  r = data_reply(usbreq_pkg::SRC_INLINE, '0, usbreq_pkg::LEN_BYTE);
                  if (intf < usbreq_pkg::MAX_INTERFACES_DEFAULT)
                     r.inline_data = {8'd0, alt_table[intf[ALT_IDX_W-1:0]]};
               end
               default: ;
            endcase
         end
         usbreq_pkg::TYPE_CLASS:
            if (regs.presence_flags[usbreq_pkg::FLAG_CLASS])
               r.result_code = usbreq_pkg::RC_CLASS;
         usbreq_pkg::TYPE_VENDOR:
            if (regs.presence_flags[usbreq_pkg::FLAG_VENDOR])
               r.result_code = usbreq_pkg::RC_VENDOR;
         default: ;
      endcase
      if (r.data_length > p.length_word)
         r.data_length = p.length_word;
      r.current_config  = active_cfg;
      r.current_address = device_addr;
      return r;
   endfunction

   function automatic usbreq_pkg::packet_type setup(logic [7:0] rtype, logic [7:0] code,
                                                    logic [15:0] value, logic [15:0] index,
                                                    logic [15:0] length);
      usbreq_pkg::packet_type p;
      p.request_type = rtype;
      p.request_code = code;
      p.value_word   = value;
      p.index_word   = index;
      p.length_word  = length;
      return p;
   endfunction

   function automatic logic [7:0] std_type(logic [4:0] recip);
      return {1'b1, usbreq_pkg::TYPE_STANDARD, recip};
   endfunction

   function automatic usbreq_pkg::packet_type random_setup();
      usbreq_pkg::packet_type p;
      int         pick;
      int         lsel;
      p.request_type = 8'($urandom);
      p.request_code = 8'($urandom);
      p.value_word   = 16'($urandom);
      p.index_word   = 16'($urandom);
      p.length_word  = 16'($urandom);
      pick = $urandom_range(99);
      if (pick < 70) begin
         p.request_type[6:5] = usbreq_pkg::TYPE_STANDARD;
         if ($urandom_range(9) < 8)
            p.request_type[4:0] = 5'($urandom_range(3));
         if (pick < 60) begin
            if ($urandom_range(9) < 4)
               p.request_code = usbreq_pkg::REQ_GET_DESCRIPTOR;
            else
               p.request_code = STD_CODES[4'($urandom_range(8))];
         end
         if ($urandom_range(9) < 7)
            p.value_word[7:0] = 8'($urandom_range(9));
         if (p.request_code == usbreq_pkg::REQ_GET_DESCRIPTOR && $urandom_range(9) < 8)
            p.value_word[15:8] = DESC_KINDS[4'($urandom_range(9))];
         if ($urandom_range(3) != 0)
            p.index_word[7:0] = 8'($urandom_range(9));
         lsel = $urandom_range(9);
         if (lsel == 0)
            p.length_word = '0;
         else if (lsel == 1)
            p.length_word = '1;
         else if (lsel < 6)
            p.length_word = 16'($urandom_range(20));
      end else if (pick < 85) begin
         p.request_type[6:5] = 2'($urandom_range(usbreq_pkg::TYPE_CLASS, TYPE_RESERVED));
      end
      return p;
   endfunction

   task automatic queue_setup(usbreq_pkg::packet_type p);
      pending_setups.push_back(p);
      setups_queued++;
   endtask

   task automatic compare_field(string field, logic [15:0] want, logic [15:0] got);
      if (want !== got) begin
         $display("%0t: %s expected 0x%0h, got 0x%0h", $time, field, want, got);
         failures++;
      end
   endtask

   task automatic write_register(logic [usbreq_pkg::CSR_INDEX_W-1:0] idx,
                                 logic [usbreq_pkg::CSR_DATA_W-1:0] v);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= v;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         usbreq_pkg::CSR_CONFIG_COUNT:    regs.config_count         = v[7:0];
         usbreq_pkg::CSR_STRING_COUNT:    regs.string_count         = v[3:0];
         usbreq_pkg::CSR_STRING_LENGTHS:  regs.string_lengths       = v;
         usbreq_pkg::CSR_CONFIG_DESC_LEN: regs.config_desc_length   = v[15:0];
         usbreq_pkg::CSR_REPORT_DESC_LEN: regs.report_desc_length   = v[15:0];
         usbreq_pkg::CSR_BOS_DESC_LEN:    regs.bos_desc_length      = v[15:0];
         usbreq_pkg::CSR_LANGUAGE_LEN:    regs.language_desc_length = v[7:0];
         usbreq_pkg::CSR_PRESENCE_FLAGS:  regs.presence_flags       = v[7:0];
         default: ;
      endcase
      csr_valid <= 1'b0;
   endtask

   task automatic configure(int kind);
      logic [63:0] v;
      for (int k = usbreq_pkg::CSR_CONFIG_COUNT; k <= usbreq_pkg::CSR_PRESENCE_FLAGS; k++) begin
         v = {$urandom, $urandom};
         case (8'(k))
            usbreq_pkg::CSR_CONFIG_COUNT:
               if ($urandom_range(9) < 7) v[7:0] = 8'($urandom_range(4));
            usbreq_pkg::CSR_STRING_COUNT:
               v[3:0] = 4'($urandom_range(10));
            usbreq_pkg::CSR_STRING_LENGTHS:
               for (int b = 0; b < 8; b++)
                  if ($urandom_range(3) == 0) v[b*8 +: 8] = '0;
            usbreq_pkg::CSR_CONFIG_DESC_LEN, usbreq_pkg::CSR_REPORT_DESC_LEN,
            usbreq_pkg::CSR_BOS_DESC_LEN:
               if ($urandom_range(4) == 0) v[15:0] = '0;
            usbreq_pkg::CSR_LANGUAGE_LEN:
               if ($urandom_range(4) == 0) v[7:0] = '0;
            default: ;
         endcase
         if (kind == 0) v = '1;
         if (kind == 1) v = '0;
         write_register(8'(k), v);
      end
      settings_used++;
   endtask

   task automatic drain();
      do @(negedge clock);
      while (setups_accepted != setups_queued || replies_checked != setups_accepted);
   endtask

   // driver: hold payload until the transaction completes, then advance
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            expected_replies.push_back(respond(offered));
            setups_accepted++;
         end
         if (!req_valid || req_ready) begin
            if (pending_setups.size() != 0 && $urandom_range(99) >= idle_pct) begin
               offered = pending_setups.pop_front();
               req_valid        <= 1'b1;
               req_request_type <= offered.request_type;
               req_request_code <= offered.request_code;
               req_value_word   <= offered.value_word;
               req_index_word   <= offered.index_word;
               req_length_word  <= offered.length_word;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor: check each reply, drop ready at random or for a long hold
   always @(posedge clock) begin
      usbreq_pkg::reply_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_replies.size() == 0) begin
               $display("%0t: reply with nothing expected, result_code 0x%0h",
                        $time, rsp_result_code);
               failures++;
            end else begin
               want = expected_replies.pop_front();
               reply_tally[want.result_code]++;
               compare_field("result_code", 16'(want.result_code), 16'(rsp_result_code));
               compare_field("data_source", 16'(want.data_source), 16'(rsp_data_source));
               compare_field("source_index", 16'(want.source_index),
                             16'(rsp_source_index));
               compare_field("inline_data", want.inline_data, rsp_inline_data);
               compare_field("data_length", want.data_length, rsp_data_length);
               compare_field("config_notify", 16'(want.config_notify),
                             16'(rsp_config_notify));
               compare_field("current_config", 16'(want.current_config),
                             16'(rsp_current_config));
               compare_field("current_address", 16'(want.current_address),
                             16'(rsp_current_address));
            end
            replies_checked++;
            if (replies_checked % 400 == 150)
               hold_left = 90;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= idle_pct);
         end
      end
   end

   initial begin
      #2000000;
      $display("usb_standard_request_responder: mismatch");
      $finish;
   end

   initial begin
      regs = '0;
      regs.config_count         = 8'd1;
      regs.language_desc_length = 8'd4;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      queue_setup(setup(std_type(5'd0), usbreq_pkg::REQ_GET_CONFIGURATION, 16'h0000,
                        16'h0000, 16'h0001));
      queue_setup(setup(std_type(5'd0), usbreq_pkg::REQ_GET_STATUS, 16'h0000, 16'h0000,
                        16'hFFFF));
      queue_setup(setup(std_type(5'd3), usbreq_pkg::REQ_GET_STATUS, 16'h0000, 16'h0000,
                        16'h0002));
      queue_setup(setup(std_type(5'd2), usbreq_pkg::REQ_GET_STATUS, 16'h0000, 16'h0081,
                        16'h0001));
      queue_setup(setup(std_type(5'd0), usbreq_pkg::REQ_SET_ADDRESS, 16'hFFFF, 16'h0000,
                        16'h0000));
      queue_setup(setup(std_type(5'd0), usbreq_pkg::REQ_SET_CONFIGURATION, 16'h0001,
                        16'h0000, 16'h0000));
      queue_setup(setup(std_type(5'd0), usbreq_pkg::REQ_GET_CONFIGURATION, 16'h0000,
                        16'h0000, 16'h0000));
      queue_setup(setup(std_type(5'd0), usbreq_pkg::REQ_SET_CONFIGURATION, 16'h0002,
                        16'h0000, 16'h0000));
      queue_setup(setup(std_type(5'd0), usbreq_pkg::REQ_SET_CONFIGURATION, 16'hFF00,
                        16'h0000, 16'h0000));
      queue_setup(setup(std_type(5'd0), usbreq_pkg::REQ_SET_FEATURE, 16'h0001, 16'h0000,
                        16'h0000));
      queue_setup(setup(std_type(5'd2), usbreq_pkg::REQ_CLEAR_FEATURE, 16'h0000, 16'h0081,
                        16'h0000));
      queue_setup(setup(std_type(5'd1), usbreq_pkg::REQ_SET_INTERFACE, 16'h00FF, 16'hFF07,
                        16'h0000));
      queue_setup(setup(std_type(5'd1), usbreq_pkg::REQ_SET_INTERFACE, 16'h0005, 16'h0008,
                        16'h0000));
      queue_setup(setup(std_type(5'd1), usbreq_pkg::REQ_GET_INTERFACE, 16'h0000, 16'h0007,
                        16'h0001));
      queue_setup(setup(std_type(5'd1), usbreq_pkg::REQ_GET_INTERFACE, 16'h0000, 16'h00FF,
                        16'h0001));
      queue_setup(setup(std_type(5'd0), usbreq_pkg::REQ_GET_DESCRIPTOR,
                        {usbreq_pkg::DT_DEVICE, 8'h00}, 16'h0000, 16'h0040));
      queue_setup(setup(std_type(5'd0), usbreq_pkg::REQ_GET_DESCRIPTOR,
                        {usbreq_pkg::DT_STRING, 8'h00}, 16'h0000, 16'h00FF));
      queue_setup(setup(std_type(5'd0), usbreq_pkg::REQ_GET_DESCRIPTOR,
                        {usbreq_pkg::DT_STRING, 8'h01}, 16'h0409, 16'h00FF));
      queue_setup(setup(std_type(5'd0), usbreq_pkg::REQ_GET_DESCRIPTOR,
                        {usbreq_pkg::DT_QUALIFIER, 8'h00}, 16'h0000, 16'h000A));
      queue_setup(setup(std_type(5'd0), usbreq_pkg::REQ_GET_DESCRIPTOR,
                        {usbreq_pkg::DT_CONFIG, 8'h00}, 16'h0000, 16'hFFFF));
      queue_setup(setup(std_type(5'd0), usbreq_pkg::REQ_GET_DESCRIPTOR, 16'hFFFF, 16'h0000,
                        16'h0040));
      queue_setup(setup({1'b1, usbreq_pkg::TYPE_CLASS, 5'd1}, 8'h01, 16'h0000, 16'h0000,
                        16'h0008));
      queue_setup(setup({1'b0, usbreq_pkg::TYPE_VENDOR, 5'd0}, 8'hFF, 16'hFFFF, 16'hFFFF,
                        16'hFFFF));
      queue_setup(setup({1'b1, TYPE_RESERVED, 5'd31}, usbreq_pkg::REQ_GET_STATUS, 16'h0000,
                        16'h0000, 16'h0002));
      queue_setup(setup(std_type(5'd0), REQ_SET_DESCRIPTOR, 16'h0100, 16'h0000, 16'h0012));
      drain();

      foreach (PHASE_KINDS[ph]) begin
         configure(PHASE_KINDS[ph]);
         idle_pct = (ph == NO_IDLE_PHASE) ? 0 : 35;
         @(negedge clock);
         repeat (SETUPS_PER_PHASE) queue_setup(random_setup());
         drain();
      end

      repeat (10) @(negedge clock);
      if (expected_replies.size() != 0) begin
         $display("%0t: %0d replies never arrived", $time, expected_replies.size());
         failures++;
      end
      $display("%0d setup packets answered under %0d register settings plus reset defaults",
               replies_checked, settings_used);
      $display("%0d data, %0d no-data, %0d stalled, %0d forwarded replies",
               reply_tally[usbreq_pkg::RC_DATA], reply_tally[usbreq_pkg::RC_NODATA],
               reply_tally[usbreq_pkg::RC_STALL],
               reply_tally[usbreq_pkg::RC_CLASS] + reply_tally[usbreq_pkg::RC_VENDOR]
               + reply_tally[usbreq_pkg::RC_DESC_FWD]
               + reply_tally[usbreq_pkg::RC_STRING_FWD]);
      if (failures == 0)
         $display("usb_standard_request_responder: match");
      else
         $display("usb_standard_request_responder: mismatch");
      $finish;
   end

endmodule

// ===== usb_standard_request_responder.f =====
src/usbreq_pkg.sv
src/usbreq_csr.sv
src/usbreq_state.sv
src/usbreq_decode.sv
src/usb_standard_request_responder.sv
verif/usb_standard_request_responder_test.sv
